### hw/rtl/sb64_pkg.sv
// Shared types, constants and the character decode function for the base64 key decoder.
`default_nettype none

package sb64_pkg;

    // Character codes with a meaning of their own.
    localparam logic [7:0] SB64_CHAR_PAD   = 8'h3D;
    localparam logic [7:0] SB64_CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] SB64_CHAR_SLASH = 8'h2F;
    localparam logic [7:0] SB64_CHAR_UC_A  = 8'h41;
    localparam logic [7:0] SB64_CHAR_UC_Z  = 8'h5A;
    localparam logic [7:0] SB64_CHAR_LC_A  = 8'h61;
    localparam logic [7:0] SB64_CHAR_LC_Z  = 8'h7A;
    localparam logic [7:0] SB64_CHAR_NUM_0 = 8'h30;
    localparam logic [7:0] SB64_CHAR_NUM_9 = 8'h39;

    // Digit values of the two symbol characters.
    localparam logic [5:0] SB64_DIGIT_PLUS  = 6'd62;
    localparam logic [5:0] SB64_DIGIT_SLASH = 6'd63;

    // Saturation points of the character and byte counters.
    localparam logic [9:0] SB64_IN_SAT  = 10'h3FF;
    localparam logic [8:0] SB64_OUT_SAT = 9'h1FF;

    // Default limit on the decoded size of one key.
    localparam int SB64_MAX_OUT_BYTES = 250;

    // Decoder state that persists from one character to the next.
    typedef struct packed {
        logic [5:0] left_bits;
        logic [2:0] left_cnt;
        logic       pad_seen;
        logic [1:0] pad_cnt;
        logic [9:0] in_cnt;
        logic [8:0] out_cnt;
        logic       err;
    } t_sb64_state;

    // Decoded character: a 6-bit digit and a flag for characters outside the alphabet.
    typedef struct packed {
        logic       invalid;
        logic [5:0] value;
    } t_sb64_digit;

    function automatic t_sb64_digit sb64_digit(input logic [7:0] c);
        t_sb64_digit d;
        d.invalid = 1'b0;
        d.value   = 6'd0;
        if (c >= SB64_CHAR_UC_A && c <= SB64_CHAR_UC_Z) begin
            d.value = 6'(c - SB64_CHAR_UC_A);
        end else if (c >= SB64_CHAR_LC_A && c <= SB64_CHAR_LC_Z) begin
            // 'a' maps to 26.
            d.value = 6'(c - (SB64_CHAR_LC_A - 8'd26));
        end else if (c >= SB64_CHAR_NUM_0 && c <= SB64_CHAR_NUM_9) begin
            // '0' maps to 52.
            d.value = 6'(c + (8'd52 - SB64_CHAR_NUM_0));
        end else if (c == SB64_CHAR_PLUS) begin
            d.value = SB64_DIGIT_PLUS;
        end else if (c == SB64_CHAR_SLASH) begin
            d.value = SB64_DIGIT_SLASH;
        end else begin
            d.invalid = 1'b1;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

### hw/rtl/sb64_in_if.sv
// Request channel that carries one encoded character and its end-of-string flag.
`default_nettype none

interface sb64_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

`default_nettype wire

### hw/rtl/sb64_out_if.sv
// Result channel that carries a decoded byte and the end-of-string verdict.
`default_nettype none

interface sb64_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       done_res;
    logic       status;

    modport source (output valid, output data_byte, output byte_valid,
                    output done_res, output status, input ready);
    modport sink   (input valid, input data_byte, input byte_valid,
                    input done_res, input status, output ready);
endinterface

`default_nettype wire

### hw/rtl/sb64_verdict.sv
// End-of-string checks that decide whether the whole key was canonical base64.
`default_nettype none

module sb64_verdict
    import sb64_pkg::*;
#(
    parameter int MAX_OUT_BYTES = SB64_MAX_OUT_BYTES
) (
    input  t_sb64_state i_st,
    output logic        o_bad
);

    localparam logic [8:0] MaxOut = 9'(MAX_OUT_BYTES);

    logic [1:0]  rem;
    logic [7:0]  quads;
    logic [9:0]  quads_x3;
    logic [1:0]  extra;
    logic [10:0] expected;

    always_comb begin
        rem      = i_st.in_cnt[1:0];
        quads    = i_st.in_cnt[9:2];
        quads_x3 = {2'b00, quads} + {1'b0, quads, 1'b0};
        case (rem)
            2'd2:    extra = 2'd1;
            2'd3:    extra = 2'd2;
            default: extra = 2'd0;
        endcase
        // A negative expected size wraps to a large value and so never matches.
        expected = {1'b0, quads_x3} + {9'd0, extra} - {9'd0, i_st.pad_cnt};

        o_bad = i_st.err
             || (i_st.in_cnt == SB64_IN_SAT)
             || (rem == 2'd1)
             || (i_st.pad_cnt != 2'd0 && rem != 2'd0)
             || (i_st.pad_cnt == 2'd1 && i_st.left_cnt != 3'd2)
             || (i_st.pad_cnt == 2'd2 && i_st.left_cnt != 3'd4)
             || (i_st.left_cnt != 3'd0 && i_st.left_bits != 6'd0)
             || ({2'b00, i_st.out_cnt} != expected)
             || (i_st.out_cnt == 9'd0)
             || (i_st.out_cnt > MaxOut);
    end

endmodule

`default_nettype wire

### hw/rtl/strict_base64_key_decoder.sv
// Top level of the strict base64 key decoder: request register, decode logic and result register.
//
// The decoder takes one character of a standard base64 string per request and
// returns exactly one result per request, one request per clock when the result
// side keeps taking results. A request is held in an input register, decoded by
// one shallow level of logic (alphabet lookup, 12-bit accumulator, counters and
// the end-of-string checks) and written to a result register. A result is
// offered only after its request has moved from the input register into
// the result register and can be taken from there. The input register and
// the result register each hold one item, so while a result waits the block
// still takes one more request and only then stalls its request side. Each
// completed byte is shown with byte_valid on the result of the character that
// completed it. The result of the character flagged last_char carries done_res
// and the verdict in status (1 for a string that is not canonical base64 or
// whose decoded size is zero, inconsistent with its length, or above
// MAX_OUT_BYTES). Bytes are shown before the verdict, so the consumer must drop
// the bytes of a string whose verdict is an error; once an error has been seen,
// no further bytes are shown for that string. After the last character all
// decoder state returns to its reset value.
`default_nettype none

module strict_base64_key_decoder
    import sb64_pkg::*;
#(
    parameter int MAX_OUT_BYTES = SB64_MAX_OUT_BYTES
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    sb64_in_if.sink           i_char_if,
    sb64_out_if.source        o_res_if
);

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_char;
    logic        r_in_last;

    // Result register.
    logic        r_out_valid;
    logic [7:0]  r_out_byte;
    logic        r_out_bvalid;
    logic        r_out_done;
    logic        r_out_status;

    // Decoder state carried from character to character.
    t_sb64_state r_st;
    t_sb64_state n_st;
    t_sb64_state upd_st;

    logic        advance;
    logic        take;

    t_sb64_digit dig;
    logic [11:0] acc;
    logic [3:0]  cnt_sum;
    logic [2:0]  cnt_new;
    logic [11:0] acc_shift;
    logic [7:0]  n_byte;
    logic        n_bvalid;
    logic        verdict_bad;

    // The held request moves into the result register whenever that register
    // is empty or its result is being taken in this cycle.
    assign advance = r_in_valid && (!r_out_valid || o_res_if.ready);

    // The input register takes a new request when it is empty or is emptied now.
    assign i_char_if.ready = i_rst_n && (!r_in_valid || advance);
    assign take            = i_char_if.valid && i_char_if.ready;

    // Decode of one character against the current state.
    always_comb begin
        upd_st    = r_st;
        dig       = sb64_digit(r_in_char);
        acc       = {r_st.left_bits, dig.value};
        cnt_sum   = {1'b0, r_st.left_cnt} + 4'd6;
        cnt_new   = cnt_sum[2:0];
        acc_shift = 12'd0;
        n_byte    = 8'd0;
        n_bvalid  = 1'b0;

        if (r_st.in_cnt != SB64_IN_SAT) begin
            upd_st.in_cnt = r_st.in_cnt + 10'd1;
        end

        if (r_in_char == SB64_CHAR_PAD) begin
            upd_st.pad_seen = 1'b1;
            if (r_st.pad_cnt == 2'd2) begin
                upd_st.err = 1'b1;
            end else begin
                upd_st.pad_cnt = r_st.pad_cnt + 2'd1;
            end
        end else if (r_st.pad_seen || dig.invalid) begin
            // A digit after padding, or a character outside the alphabet.
            upd_st.err = 1'b1;
        end else begin
            if (cnt_sum[3]) begin
                // At least eight bits are ready: the top eight form a byte.
                cnt_new   = 3'(cnt_sum - 4'd8);
                acc_shift = acc >> cnt_new;
                n_byte    = acc_shift[7:0];
                n_bvalid  = 1'b1;
                if (r_st.out_cnt != SB64_OUT_SAT) begin
                    upd_st.out_cnt = r_st.out_cnt + 9'd1;
                end
            end
            upd_st.left_bits = acc[5:0] & ~(6'h3F << cnt_new);
            upd_st.left_cnt  = cnt_new;
        end

        // After an error no byte goes out.
        if (upd_st.err) begin
            n_byte   = 8'd0;
            n_bvalid = 1'b0;
        end

        // The last character closes the string and starts a fresh one.
        n_st = r_in_last ? '0 : upd_st;
    end

    sb64_verdict #(
        .MAX_OUT_BYTES (MAX_OUT_BYTES)
    ) u_verdict (
        .i_st  (upd_st),
        .o_bad (verdict_bad)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st        <= '0;
        end else begin
            if (take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end

            if (advance) begin
                r_out_valid <= 1'b1;
                r_st        <= n_st;
            end else if (o_res_if.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge i_clk) begin
        if (take) begin
            r_in_char <= i_char_if.char_code;
            r_in_last <= i_char_if.last_char;
        end
        if (advance) begin
            r_out_byte   <= n_byte;
            r_out_bvalid <= n_bvalid;
            r_out_done   <= r_in_last;
            r_out_status <= r_in_last && verdict_bad;
        end
    end

    assign o_res_if.valid      = r_out_valid;
    assign o_res_if.data_byte  = r_out_byte;
    assign o_res_if.byte_valid = r_out_bvalid;
    assign o_res_if.done_res   = r_out_done;
    assign o_res_if.status     = r_out_status;

endmodule

`default_nettype wire

### hw/rtl/sb64_checker.sv
// Port-level checks on the base64 key decoder and the bind that attaches them.
`default_nettype none

module sb64_checker (
    input logic i_clk,
    input logic i_rst_n,
    input logic i_in_valid,
    input logic i_in_ready,
    input logic i_out_valid,
    input logic i_out_ready
);

    // A result held back by the consumer stays offered.
    a_out_hold: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (i_out_valid && !i_out_ready) |=> i_out_valid
    ) else $error("result withdrawn while stalled");

    // Reset empties the result register.
    a_reset_empty: assert property (
        @(posedge i_clk)
        $past(!i_rst_n) |-> !i_out_valid
    ) else $error("result offered right after reset");

    // A newly offered result follows a request that was taken and held in the input register.
    a_no_invented: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_out_valid) |-> $past(i_in_valid && i_in_ready, 2)
    ) else $error("result without a matching request");

endmodule

bind strict_base64_key_decoder sb64_checker u_sb64_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_char_if.valid),
    .i_in_ready  (i_char_if.ready),
    .i_out_valid (o_res_if.valid),
    .i_out_ready (o_res_if.ready)
);

`default_nettype wire
